// ===== rtl/core/stb_pkg.sv =====
// Shared types and codes for the software timer bank.
package stb_pkg;

  localparam int SLOTS_DEFAULT = 8;
  localparam int MAX_WALK = 8;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ARM      = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_CD_START = 3'd3;
  localparam logic [2:0] CMD_CD_STOP  = 3'd4;
  localparam logic [2:0] CMD_QUERY    = 3'd5;

  localparam logic [1:0] MODE_ONCE   = 2'd0;
  localparam logic [1:0] MODE_REPEAT = 2'd1;

  typedef struct packed {
    logic        start;
    logic        step;
    logic        clear;
    logic [2:0]  cmd;
    logic [15:0] load;
    logic [1:0]  mode;
    logic        notify;
  } stb_ctl_t;

  typedef struct packed {
    logic        fire;
    logic [15:0] alarm_elapsed;
    logic [15:0] countdown_elapsed;
    logic        alarm_running;
    logic        countdown_running;
  } stb_rpt_t;

endpackage

// ===== rtl/core/stb_cell.sv =====
// One timer slot of the bank, with the walk token handed on to the next slot.
module stb_cell
  import stb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  stb_ctl_t ctl,
  input  logic     wr,
  input  logic     sel,
  input  logic     token_in,
  output logic     token_out,
  output stb_rpt_t rpt
);

  logic [15:0] a_count;
  logic [15:0] a_reload;
  logic        a_en;
  logic [1:0]  a_mode;
  logic        a_notify;
  logic [15:0] c_count;
  logic [15:0] c_reload;
  logic        c_en;
  logic        token;

  logic [15:0] a_dec;
  logic [15:0] c_dec;
  logic [15:0] a_count_next;
  logic        a_en_next;
  logic [15:0] c_count_next;
  logic        c_en_next;
  logic        fire;

  assign a_dec = (a_count != 16'd0) ? a_count - 16'd1 : a_count;
  assign c_dec = (c_count != 16'd0) ? c_count - 16'd1 : c_count;

  always_comb begin
    a_count_next = a_count;
    a_en_next    = a_en;
    fire         = 1'b0;
    if (a_en) begin
      a_count_next = a_dec;
      if (a_dec == 16'd0) begin
        if (a_mode == MODE_REPEAT) begin
          a_count_next = a_reload;
        end else if (a_mode == MODE_ONCE) begin
          a_en_next = 1'b0;
        end
        fire = a_notify;
      end
    end
  end

  always_comb begin
    c_count_next = c_count;
    c_en_next    = c_en;
    if (c_en) begin
      c_count_next = c_dec;
      if (c_dec == 16'd0) begin
        c_en_next = 1'b0;
      end
    end
  end

  always_comb begin
    rpt = '0;
    if (token) begin
      rpt.fire              = fire;
      rpt.alarm_elapsed     = a_reload - a_count_next;
      rpt.countdown_elapsed = c_reload - c_count_next;
      rpt.alarm_running     = a_en_next;
      rpt.countdown_running = c_en_next;
    end else if (sel) begin
      rpt.alarm_elapsed     = a_reload - a_count;
      rpt.countdown_elapsed = c_reload - c_count;
      rpt.alarm_running     = a_en;
      rpt.countdown_running = c_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_count  <= '0;
      a_reload <= '0;
      a_en     <= 1'b0;
      a_mode   <= '0;
      a_notify <= 1'b0;
      c_count  <= '0;
      c_reload <= '0;
      c_en     <= 1'b0;
    end else if (wr) begin
      unique case (ctl.cmd)
        CMD_ARM: begin
          a_count  <= ctl.load;
          a_reload <= ctl.load;
          a_en     <= 1'b1;
          a_mode   <= ctl.mode;
          a_notify <= ctl.notify;
        end
        CMD_STOP: begin
          a_count <= '0;
          a_en    <= 1'b0;
        end
        CMD_CD_START: begin
          c_count  <= ctl.load;
          c_reload <= ctl.load;
          c_en     <= 1'b1;
        end
        CMD_CD_STOP: begin
          c_count <= '0;
          c_en    <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (token && ctl.step) begin
      a_count <= a_count_next;
      a_en    <= a_en_next;
      c_count <= c_count_next;
      c_en    <= c_en_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
    end else if (ctl.step) begin
      token <= ctl.clear ? 1'b0 : token_in;
    end else if (ctl.start) begin
      token <= token_in;
    end
  end

  assign token_out = token;

endmodule

// ===== rtl/core/software_timer_bank.sv =====
// Top level of the software timer bank: command decode, tick walk and output stage.
//
// Input words on s_* carry a command: tick, arm alarm, stop alarm, start
// countdown, stop countdown or query. Output words on m_* carry one result
// each; m_tuser is the fired flag and m_tlast marks the final word of a command.
// The slot count to walk per tick is written through cfg_wr_en and cfg_wr_data.
// A command other than a tick (codes one to five) is taken in the idle state;
// its single result word is loaded into the output register from ST_CMD once
// the register has space, and no new command is taken until then.
// A tick passes a token down the row of slot cells, one slot per cycle unless
// the walk stalls, over a walk length of at most eight. A fire result is held
// one slot back so that the last one can be flagged; the final word is loaded
// from ST_FIN once the output register has space. Codes six and seven are dropped.
// When the receiver stalls with a fire result pending, the walk stops at the next
// firing slot and no new command is taken until the pending words can move on.
// Reset clears every slot, the tick total, the slot count and the output.
module software_timer_bank
  import stb_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [3:0]   cfg_wr_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cmd[2:0], slot[5:3], load_value[21:6], repeat_mode[23:22], has_callback[24]
  input  logic [31:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_slot[2:0], alarm_elapsed[18:3], countdown_elapsed[34:19],
  // alarm_running[35], countdown_running[36], elapsed_ms[100:37]
  output logic [103:0] m_tdata,
  // fired[0]
  output logic         m_tuser,
  output logic         m_tlast
);

  localparam int WALK_MAX = (SLOTS < MAX_WALK) ? SLOTS : MAX_WALK;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMD  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]  state;
  logic [3:0]  active_slots;
  logic [63:0] tick_total;
  logic [2:0]  idx;
  logic [2:0]  cmd_slot;

  logic        ovalid;
  logic [2:0]  o_slot;
  logic        o_last;
  stb_rpt_t    o_rpt;
  logic [63:0] o_ms;

  logic        pvalid;
  logic [2:0]  p_slot;
  stb_rpt_t    p_rpt;

  logic [2:0]  in_cmd;
  logic [2:0]  in_slot;
  logic        accept;
  logic        cmd_wr;
  logic [3:0]  walk_len;
  logic        last_idx;
  logic        space;
  logic        go;
  logic        push;
  logic [2:0]  push_slot;
  logic        push_last;
  stb_rpt_t    push_rpt;

  stb_ctl_t               ctl;
  logic [SLOTS-1:0]       token;
  stb_rpt_t [SLOTS-1:0]   rpt_cell;
  stb_rpt_t               rpt;

  assign in_cmd  = s_tdata[2:0];
  assign in_slot = s_tdata[5:3];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cmd_wr   = accept && (in_cmd == CMD_ARM || in_cmd == CMD_STOP ||
                               in_cmd == CMD_CD_START || in_cmd == CMD_CD_STOP);

  assign walk_len = (32'(active_slots) > WALK_MAX) ? 4'(WALK_MAX) : active_slots;
  assign last_idx = ({1'b0, idx} == walk_len - 4'd1);
  assign space    = !ovalid || m_tready;
  assign go       = (state == ST_WALK) && !(rpt.fire && pvalid && !space);

  assign ctl.start  = accept && (in_cmd == CMD_TICK) && (walk_len != 4'd0);
  assign ctl.step   = go;
  assign ctl.clear  = go && last_idx;
  assign ctl.cmd    = in_cmd;
  assign ctl.load   = s_tdata[21:6];
  assign ctl.mode   = s_tdata[23:22];
  assign ctl.notify = s_tdata[24];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic tin;
    if (i == 0) begin : g_head
      assign tin = ctl.start;
    end else begin : g_link
      assign tin = token[i-1];
    end
    stb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wr        (cmd_wr && (32'(in_slot) == i)),
      .sel       ((state == ST_CMD) && (32'(cmd_slot) == i)),
      .token_in  (tin),
      .token_out (token[i]),
      .rpt       (rpt_cell[i])
    );
  end

  always_comb begin
    rpt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      rpt = rpt | rpt_cell[i];
    end
  end

  always_comb begin
    push      = 1'b0;
    push_slot = cmd_slot;
    push_last = 1'b1;
    push_rpt  = rpt;
    unique case (state)
      ST_CMD: begin
        push = space;
      end
      ST_WALK: begin
        push      = go && rpt.fire && pvalid;
        push_slot = p_slot;
        push_last = 1'b0;
        push_rpt  = p_rpt;
      end
      ST_FIN: begin
        push      = space;
        push_slot = p_slot;
        push_rpt  = p_rpt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_slots <= '0;
      tick_total   <= '0;
      idx          <= '0;
      cmd_slot     <= '0;
      pvalid       <= 1'b0;
      ovalid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_slots <= cfg_wr_data;
      end
      if (push) begin
        ovalid <= 1'b1;
      end else if (m_tready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_slot <= in_slot;
            idx      <= '0;
            if (in_cmd == CMD_TICK) begin
              tick_total <= tick_total + 64'd1;
              if (walk_len != 4'd0) begin
                state <= ST_WALK;
              end
            end else if (in_cmd <= CMD_QUERY) begin
              state <= ST_CMD;
            end
          end
        end
        ST_CMD: begin
          if (space) begin
            state <= ST_IDLE;
          end
        end
        ST_WALK: begin
          if (go) begin
            if (rpt.fire) begin
              pvalid <= 1'b1;
            end
            if (last_idx) begin
              state <= (pvalid || rpt.fire) ? ST_FIN : ST_IDLE;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        ST_FIN: begin
          if (space) begin
            pvalid <= 1'b0;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go && rpt.fire) begin
      p_slot <= idx;
      p_rpt  <= rpt;
    end
    if (push) begin
      o_slot <= push_slot;
      o_last <= push_last;
      o_rpt  <= push_rpt;
      o_ms   <= tick_total;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tuser  = o_rpt.fire;
  assign m_tlast  = o_last;
  assign m_tdata  = {3'b000, o_ms, o_rpt.countdown_running, o_rpt.alarm_running,
                     o_rpt.countdown_elapsed, o_rpt.alarm_elapsed, o_slot};

  a_token_single: assert property (@(posedge clk) disable iff (rst) $onehot0(token))
    else $error("more than one slot holds the walk token");

  a_token_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> $onehot(token))
    else $error("walk in progress without a token");

  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_CMD) |-> !pvalid)
    else $error("fire result left pending outside a walk");

  a_fin_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> pvalid)
    else $error("final flush without a pending result");

endmodule
